@@ sv/bffa_pkg.sv @@
// Shared types and constants for the bitmap first-free allocator.
// Used by bitmap_first_free_allocator; depends on nothing.
package bffa_pkg;

  // Bitmap word held in one memory entry
  localparam int WORD_W    = 64;
  localparam int WORD_BITS = 6;

  // Field widths of the request and result ports
  localparam int POOL_W   = 14;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_e;

endpackage

@@ sv/bffa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bitmap_first_free_allocator.sv @@
// Top level of the bitmap first-free allocator.
// Depends on bffa_pkg and bffa_ram (bitmap storage).
//
// The block keeps its usage bitmap in a RAM of 64-bit words and a pointer to
// the lowest word that may still hold a free entry. After reset it runs a
// clearing pass that zeroes every word of the bitmap with busy high; pool_size
// writes are taken during it. A request is taken when start is high and busy is
// low, and its result appears on done_o for exactly one cycle; the result must
// be taken then. A release outside the pool returns in the cycle after it is
// taken; any other release passes through the read and evaluate states first.
// An allocate reads and evaluates each fully used word it steps over from the
// pointer, so the cost follows how far the lowest free entry has moved since
// the last scan. busy falls in the cycle the result is shown, so the next
// request may be issued during that cycle.
module bitmap_first_free_allocator #(
  parameter int MAP_ENTRIES = 8192
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pool_size_we_i,
  input  logic [bffa_pkg::POOL_W-1:0]  pool_size_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [bffa_pkg::POOL_W-1:0]  entry_number_i,
  output logic                         done_o,
  output logic [bffa_pkg::POOL_W-1:0]  granted_number_o,
  output logic [bffa_pkg::STATUS_W-1:0] status_o,
  output logic [bffa_pkg::POOL_W-1:0]  free_count_o
);

  localparam int NW = (MAP_ENTRIES + bffa_pkg::WORD_W - 1) / bffa_pkg::WORD_W;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW = $clog2(MAP_ENTRIES + 1);
  localparam int EW = (CW > bffa_pkg::POOL_W) ? CW : bffa_pkg::POOL_W;
  localparam int BW = EW + 1;
  localparam int WW = bffa_pkg::WORD_W;
  localparam int WB = bffa_pkg::WORD_BITS;

  bffa_pkg::state_e  state_q, state_d;
  logic [bffa_pkg::POOL_W-1:0] pool_q;
  logic [CW-1:0]     used_q, used_d;
  logic [AW-1:0]     lo_q, lo_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [WB-1:0]     bit_q, bit_d;
  bffa_pkg::cmd_e    cmd_q, cmd_d;
  logic              done_q, done_d;
  logic [bffa_pkg::POOL_W-1:0] granted_q, granted_d;
  bffa_pkg::status_e status_q, status_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WW-1:0]     ram_wdata;
  logic [WW-1:0]     ram_rdata;

  logic [EW-1:0]     eff;
  logic [EW-1:0]     req_num;
  logic [EW-1:0]     rel_pos;
  logic [BW-1:0]     base;
  logic [BW-1:0]     eff_b;
  logic [BW-1:0]     rem;
  logic              base_lt;
  logic [WW-1:0]     valid_bits;
  logic [WW-1:0]     free_bits;
  logic [WW-1:0]     low_bit;
  logic [WB-1:0]     low_idx;
  logic              found;
  logic [EW-1:0]     free_full;

  // Effective pool size: the register capped at the map size
  assign eff = (EW'(pool_q) > EW'(MAP_ENTRIES)) ? EW'(MAP_ENTRIES) : EW'(pool_q);
  assign req_num = EW'(entry_number_i);
  assign rel_pos = req_num - EW'(1);

  // Entries of the current word that lie inside the pool
  assign base    = BW'(addr_q) << WB;
  assign eff_b   = BW'(eff);
  assign base_lt = base < eff_b;
  assign rem     = eff_b - base;

  always_comb begin
    for (int b = 0; b < WW; b++) begin
      valid_bits[b] = base_lt && (rem > BW'(b));
    end
  end

  assign free_bits = ~ram_rdata & valid_bits;
  assign found     = |free_bits;
  assign low_bit   = free_bits & (~free_bits + WW'(1));

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < WB; k++) begin
      for (int b = 0; b < WW; b++) begin
        if (low_bit[b] && (((b >> k) & 1) == 1)) begin
          low_idx[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    lo_d      = lo_q;
    clr_d     = clr_q;
    addr_d    = addr_q;
    bit_d     = bit_q;
    cmd_d     = cmd_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = ram_rdata;

    unique case (state_q)
      bffa_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NW - 1)) begin
          state_d = bffa_pkg::S_IDLE;
        end
      end
      bffa_pkg::S_IDLE: begin
        if (start) begin
          cmd_d = bffa_pkg::cmd_e'(command_i);
          if (command_i == bffa_pkg::CMD_ALLOC) begin
            addr_d  = lo_q;
            state_d = bffa_pkg::S_READ;
          end else if (req_num == '0 || req_num > eff) begin
            // Out-of-range release answers at once
            done_d    = 1'b1;
            granted_d = '0;
            status_d  = bffa_pkg::ST_RANGE;
          end else begin
            addr_d  = AW'(rel_pos >> WB);
            bit_d   = rel_pos[WB-1:0];
            state_d = bffa_pkg::S_READ;
          end
        end
      end
      bffa_pkg::S_READ: begin
        state_d = bffa_pkg::S_EVAL;
      end
      bffa_pkg::S_EVAL: begin
        if (cmd_q == bffa_pkg::CMD_ALLOC) begin
          if (found) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | low_bit;
            used_d    = used_q + CW'(1);
            done_d    = 1'b1;
            granted_d = bffa_pkg::POOL_W'(base + BW'(low_idx) + BW'(1));
            status_d  = bffa_pkg::ST_OK;
            state_d   = bffa_pkg::S_IDLE;
          end else if (base + BW'(WW) < eff_b) begin
            // Word fully used: move the pointer up and read the next word
            lo_d    = addr_q + AW'(1);
            addr_d  = addr_q + AW'(1);
            state_d = bffa_pkg::S_READ;
          end else begin
            done_d    = 1'b1;
            granted_d = '0;
            status_d  = bffa_pkg::ST_FULL;
            state_d   = bffa_pkg::S_IDLE;
          end
        end else begin
          done_d    = 1'b1;
          granted_d = '0;
          state_d   = bffa_pkg::S_IDLE;
          if (!ram_rdata[bit_q]) begin
            status_d = bffa_pkg::ST_FREE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(WW'(1) << bit_q);
            if (used_q != '0) begin
              used_d = used_q - CW'(1);
            end
            if (addr_q < lo_q) begin
              lo_d = addr_q;
            end
            status_d = bffa_pkg::ST_OK;
          end
        end
      end
      default: begin
        state_d = bffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bffa_pkg::S_CLEAR;
      pool_q  <= bffa_pkg::POOL_W'(8192);
      used_q  <= '0;
      lo_q    <= '0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pool_size_we_i) begin
        pool_q <= pool_size_i;
      end
      used_q <= used_d;
      lo_q   <= lo_d;
      clr_q  <= clr_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    bit_q     <= bit_d;
    cmd_q     <= cmd_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  bffa_ram #(
    .WIDTH(WW),
    .DEPTH(NW)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  // Free count saturates at zero when the pool has shrunk below the used count
  assign free_full = (EW'(used_q) >= eff) ? '0 : (eff - EW'(used_q));

  assign busy             = (state_q != bffa_pkg::S_IDLE);
  assign done_o           = done_q;
  assign granted_number_o = granted_q;
  assign status_o         = status_q;
  assign free_count_o     = bffa_pkg::POOL_W'(free_full);

`ifndef SYNTH
  a_grant_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && granted_number_o != '0) |-> (status_o == bffa_pkg::ST_OK))
    else $error("grant with non-ok status");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bffa_pkg::S_CLEAR || state_q == bffa_pkg::S_EVAL))
    else $error("bitmap write outside clear or evaluate");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q <= CW'(MAP_ENTRIES)))
    else $error("used count above map size");

  a_request_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("request taken but neither busy nor done");
`endif

endmodule
